// ===== rtl/klrpp_pkg.sv =====
// Package for the keyword likelihood-ratio peak picker.
// Holds table sizes, field widths, opcodes, register indexes and the table entry type.
// No dependencies; used by keyword_lr_peak_picker_top.
`default_nettype none

package klrpp_pkg;

   // table depth and field widths
   localparam int NUM_KEYWORDS = 64;
   localparam int KW_W         = 6;
   localparam int SCORE_W      = 32;
   localparam int TIME_W       = 24;
   localparam int OP_W         = 2;

   // packed channel widths, padded to whole bytes
   localparam int REQ_DATA_W   = 120;
   localparam int RSP_FIELDS_W = KW_W + 2 * TIME_W + SCORE_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int CSR_DATA_W   = SCORE_W;

   // request opcodes
   typedef enum logic [OP_W-1:0] {
      OP_FRAME = 2'd0,
      OP_FLUSH = 2'd1,
      OP_CLEAR = 2'd2
   } op_type;

   // configuration register indexes
   typedef enum logic {
      CSR_THR_ENABLE = 1'b0,
      CSR_THRESHOLD  = 1'b1
   } csr_idx_type;

   localparam logic signed [SCORE_W-1:0] RATIO_MIN = {1'b1, {(SCORE_W-1){1'b0}}};
   localparam logic signed [SCORE_W-1:0] RATIO_MAX = {1'b0, {(SCORE_W-1){1'b1}}};

   // one keyword entry
   typedef struct packed {
      logic signed [SCORE_W-1:0] last_ratio;
      logic signed [SCORE_W-1:0] best_ratio;
      logic [TIME_W-1:0]         best_start;
      logic [TIME_W-1:0]         best_end;
   } entry_type;

   localparam entry_type ENTRY_RESET = '{
      last_ratio: RATIO_MIN,
      best_ratio: RATIO_MIN,
      best_start: '0,
      best_end:   '0
   };

endpackage

`default_nettype wire

// ===== rtl/keyword_lr_peak_picker_top.sv =====
// Top level of the keyword likelihood-ratio peak picker.
// Depends on klrpp_pkg for widths, opcodes, register indexes and the entry type.
`default_nettype none

// Takes one request per cycle. The keyword table is a 64-entry memory: the
// entry is read when a request is accepted and updated when the request leaves
// its input register and its result (if any) goes to the output register, so
// a detection is registered in the input register and then the output register.
// A request that follows one on the same keyword gets the freshly written
// entry through a forwarding register. Per-entry valid bits, cleared by
// reset, stand in for a table clear, so the block is ready right after reset.
// Input flow stops only while the output register holds an untaken result.
module keyword_lr_peak_picker_top (
   input  wire                                clock,
   input  wire                                reset,
   // request channel
   input  wire                                req_tvalid,
   output logic                               req_tready,
   // keyword_index, word_active, filler_active, word_score, filler_score,
   // word_start_time, frame_time
   input  wire  [klrpp_pkg::REQ_DATA_W-1:0]   req_tdata,
   // opcode
   input  wire  [klrpp_pkg::OP_W-1:0]         req_tuser,
   // detection channel
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   // hit_keyword, hit_start, hit_end, hit_score, zero pad
   output logic [klrpp_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // configuration writes
   input  wire                                csr_we,
   input  wire                                csr_index,
   input  wire  [klrpp_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int KW_W    = klrpp_pkg::KW_W;
   localparam int SCORE_W = klrpp_pkg::SCORE_W;
   localparam int TIME_W  = klrpp_pkg::TIME_W;

   // request fields
   logic [KW_W-1:0]           req_kw;
   assign req_kw = req_tdata[5:0];

   // control registers
   logic                      s1_valid_ff, s1_valid_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      fwd_ff, fwd_in;
   logic [klrpp_pkg::NUM_KEYWORDS-1:0] vld_ff, vld_in;
   logic                      thr_en_ff, thr_en_in;
   logic signed [SCORE_W-1:0] thr_ff, thr_in;

   // payload registers
   logic [klrpp_pkg::OP_W-1:0] s1_op_ff, s1_op_in;
   logic [KW_W-1:0]           s1_kw_ff, s1_kw_in;
   logic                      s1_wact_ff, s1_wact_in;
   logic                      s1_fact_ff, s1_fact_in;
   logic signed [SCORE_W-1:0] s1_wscore_ff, s1_wscore_in;
   logic signed [SCORE_W-1:0] s1_fscore_ff, s1_fscore_in;
   logic [TIME_W-1:0]         s1_start_ff, s1_start_in;
   logic [TIME_W-1:0]         s1_end_ff, s1_end_in;
   logic                      rd_vld_ff, rd_vld_in;
   klrpp_pkg::entry_type      fwd_data_ff, fwd_data_in;
   logic [KW_W-1:0]           hit_kw_ff, hit_kw_in;
   logic [TIME_W-1:0]         hit_start_ff, hit_start_in;
   logic [TIME_W-1:0]         hit_end_ff, hit_end_in;
   logic signed [SCORE_W-1:0] hit_score_ff, hit_score_in;

   // keyword table
   klrpp_pkg::entry_type      kw_mem_ff [klrpp_pkg::NUM_KEYWORDS];
   klrpp_pkg::entry_type      rd_data_ff;

   // update logic
   logic                      accept;
   logic                      advance;
   logic                      in_range;
   logic                      do_write;
   logic                      do_emit;
   logic                      wr_en;
   logic                      emit;
   logic                      pass;
   logic signed [SCORE_W:0]   diff;
   logic signed [SCORE_W-1:0] ratio;
   klrpp_pkg::entry_type      cur_entry;
   klrpp_pkg::entry_type      wr_entry;

   // handshake
   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;
   assign wr_en      = advance && do_write;
   assign emit       = advance && do_emit;
   assign in_range   = {1'b0, s1_kw_ff} < (KW_W+1)'(klrpp_pkg::NUM_KEYWORDS);

   // current entry: forwarded write, stored entry or reset value
   always_comb begin
      if (fwd_ff) begin
         cur_entry = fwd_data_ff;
      end else if (rd_vld_ff) begin
         cur_entry = rd_data_ff;
      end else begin
         cur_entry = klrpp_pkg::ENTRY_RESET;
      end
   end

   // saturated likelihood ratio
   always_comb begin
      diff = {s1_wscore_ff[SCORE_W-1], s1_wscore_ff} - {s1_fscore_ff[SCORE_W-1], s1_fscore_ff};
      if (diff[SCORE_W] != diff[SCORE_W-1]) begin
         ratio = diff[SCORE_W] ? klrpp_pkg::RATIO_MIN : klrpp_pkg::RATIO_MAX;
      end else begin
         ratio = diff[SCORE_W-1:0];
      end
   end

   // emission test on the pending candidate
   assign pass = (cur_entry.best_end != '0) &&
                 (!thr_en_ff || (cur_entry.best_ratio > thr_ff));

   // entry update and detection decision
   always_comb begin
      wr_entry = cur_entry;
      do_write = 1'b0;
      do_emit  = 1'b0;
      if (s1_valid_ff && in_range) begin
         case (s1_op_ff)
            klrpp_pkg::OP_FRAME: begin
               do_write = 1'b1;
               if (!(s1_wact_ff && s1_fact_ff)) begin
                  wr_entry.last_ratio = klrpp_pkg::RATIO_MIN;
               end else begin
                  wr_entry.last_ratio = ratio;
                  // ratio not below the last one that is not beaten by an overlapping candidate
                  if (!(cur_entry.last_ratio > ratio) &&
                      !(cur_entry.best_ratio > ratio && cur_entry.best_end > s1_start_ff)) begin
                     do_emit             = (cur_entry.best_end <= s1_start_ff) && pass;
                     wr_entry.best_ratio = ratio;
                     wr_entry.best_start = s1_start_ff;
                     wr_entry.best_end   = s1_end_ff;
                  end
               end
            end
            klrpp_pkg::OP_FLUSH: begin
               do_emit = pass;
            end
            klrpp_pkg::OP_CLEAR: begin
               do_write = 1'b1;
               wr_entry = klrpp_pkg::ENTRY_RESET;
            end
            default: begin
            end
         endcase
      end
   end

   // next values of all registers
   always_comb begin
      // configuration
      thr_en_in = thr_en_ff;
      thr_in    = thr_ff;
      if (csr_we) begin
         case (csr_index)
            klrpp_pkg::CSR_THR_ENABLE: thr_en_in = csr_wdata[0];
            klrpp_pkg::CSR_THRESHOLD:  thr_in    = csr_wdata;
            default: begin
            end
         endcase
      end

      // input register
      s1_valid_in  = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
      s1_op_in     = accept ? req_tuser          : s1_op_ff;
      s1_kw_in     = accept ? req_kw             : s1_kw_ff;
      s1_wact_in   = accept ? req_tdata[6]       : s1_wact_ff;
      s1_fact_in   = accept ? req_tdata[7]       : s1_fact_ff;
      s1_wscore_in = accept ? req_tdata[39:8]    : s1_wscore_ff;
      s1_fscore_in = accept ? req_tdata[71:40]   : s1_fscore_ff;
      s1_start_in  = accept ? req_tdata[95:72]   : s1_start_ff;
      s1_end_in    = accept ? req_tdata[119:96]  : s1_end_ff;

      // valid bit of the entry read and forwarding from the write this cycle
      rd_vld_in   = accept ? vld_ff[req_kw] : rd_vld_ff;
      fwd_in      = accept ? (wr_en && (s1_kw_ff == req_kw)) :
                    (advance ? 1'b0 : fwd_ff);
      fwd_data_in = accept ? wr_entry : fwd_data_ff;

      vld_in = vld_ff;
      if (wr_en) begin
         vld_in[s1_kw_ff] = 1'b1;
      end

      // output register
      rsp_valid_in = emit ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
      hit_kw_in    = emit ? s1_kw_ff             : hit_kw_ff;
      hit_start_in = emit ? cur_entry.best_start : hit_start_ff;
      hit_end_in   = emit ? cur_entry.best_end   : hit_end_ff;
      hit_score_in = emit ? cur_entry.best_ratio : hit_score_ff;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fwd_ff       <= 1'b0;
         vld_ff       <= '0;
         thr_en_ff    <= 1'b0;
         thr_ff       <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         fwd_ff       <= fwd_in;
         vld_ff       <= vld_in;
         thr_en_ff    <= thr_en_in;
         thr_ff       <= thr_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      s1_op_ff     <= s1_op_in;
      s1_kw_ff     <= s1_kw_in;
      s1_wact_ff   <= s1_wact_in;
      s1_fact_ff   <= s1_fact_in;
      s1_wscore_ff <= s1_wscore_in;
      s1_fscore_ff <= s1_fscore_in;
      s1_start_ff  <= s1_start_in;
      s1_end_ff    <= s1_end_in;
      rd_vld_ff    <= rd_vld_in;
      fwd_data_ff  <= fwd_data_in;
      hit_kw_ff    <= hit_kw_in;
      hit_start_ff <= hit_start_in;
      hit_end_ff   <= hit_end_in;
      hit_score_ff <= hit_score_in;
   end

   // keyword table: one write, one registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         kw_mem_ff[s1_kw_ff] <= wr_entry;
      end
      if (accept) begin
         rd_data_ff <= kw_mem_ff[req_kw];
      end
   end

   // outputs
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(klrpp_pkg::RSP_DATA_W - klrpp_pkg::RSP_FIELDS_W){1'b0}},
                        hit_score_ff, hit_end_ff, hit_start_ff, hit_kw_ff};

`ifndef ASSERT_OFF
   // table written only by a request in the input register
   a_write_src: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> s1_valid_ff)
      else $error("table write without a request in the input register");

   // a held detection blocks the table update
   a_hold_no_write: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !wr_en)
      else $error("table written while the output register is held");

   // forwarded data belongs to the request in the input register
   a_fwd_owner: assert property (@(posedge clock) disable iff (reset)
      fwd_ff |-> s1_valid_ff)
      else $error("forwarding flag set with an empty input register");

   // a decided detection shows up next cycle
   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      emit |=> rsp_tvalid)
      else $error("detection lost between decision and output register");

   // stall only comes from an occupied input register behind a held result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (s1_valid_ff && rsp_valid_ff))
      else $error("request stalled without a held result");
`endif

endmodule

`default_nettype wire
